// ----- hdl/slt_pkg.sv -----
// slot lifecycle table: shared types, codes and defaults
// used by the interfaces, the top level and the testbench
`default_nettype none

package slt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ID_W        = 64;
  localparam int unsigned CNT7_W      = 7;
  localparam logic [6:0]  CAP_RESET   = 7'd64;

  // request codes
  localparam logic [3:0] REQ_REGISTER = 4'd0;
  localparam logic [3:0] REQ_SPAWN    = 4'd1;
  localparam logic [3:0] REQ_SLEEP    = 4'd2;
  localparam logic [3:0] REQ_WAKE     = 4'd3;
  localparam logic [3:0] REQ_DESPAWN  = 4'd4;
  localparam logic [3:0] REQ_SET_PERS = 4'd5;
  localparam logic [3:0] REQ_QUERY    = 4'd6;
  localparam logic [3:0] REQ_LIST     = 4'd7;
  localparam logic [3:0] REQ_DIRTY    = 4'd8;
  localparam logic [3:0] REQ_CKPT     = 4'd9;
  localparam logic [3:0] REQ_CLEAR    = 4'd10;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_WRONG     = 3'd2;
  localparam logic [2:0] ST_POOL_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO_ID   = 3'd4;
  localparam logic [2:0] ST_DUP       = 3'd5;
  localparam logic [2:0] ST_TBL_FULL  = 3'd6;

  // phase codes
  localparam logic [1:0] PH_DESPAWNED = 2'd0;
  localparam logic [1:0] PH_ACTIVE    = 2'd1;
  localparam logic [1:0] PH_SLEEPING  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic       changed;
    logic       keep;
    logic [1:0] phase;
  } meta_t;

  typedef struct packed {
    logic [3:0]      req_type;
    logic [ID_W-1:0] entity_id;
    logic            persistent_value;
    logic [1:0]      state_select;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        state_out;
    logic              registered_out;
    logic              persistent_out;
    logic [CNT7_W-1:0] live_count;
    logic [ID_W-1:0]   listed_id;
    logic              listed_valid;
    logic              last;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/slt_ifs.sv -----
// request and result channel interfaces, valid/ready handshake
// depends on slt_pkg for field widths
`default_nettype none

interface slt_req_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                req_type;
  logic [slt_pkg::ID_W-1:0]  entity_id;
  logic                      persistent_value;
  logic [1:0]                state_select;

  modport source (output valid, req_type, entity_id, persistent_value, state_select,
                  input ready);
  modport sink   (input valid, req_type, entity_id, persistent_value, state_select,
                  output ready);
endinterface

interface slt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [1:0]                  state_out;
  logic                        registered_out;
  logic                        persistent_out;
  logic [slt_pkg::CNT7_W-1:0]  live_count;
  logic [slt_pkg::ID_W-1:0]    listed_id;
  logic                        listed_valid;
  logic                        last;

  modport source (output valid, status, state_out, registered_out, persistent_out,
                  live_count, listed_id, listed_valid, last, input ready);
  modport sink   (input valid, status, state_out, registered_out, persistent_out,
                  live_count, listed_id, listed_valid, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/slt_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// standalone, no package dependency
`default_nettype none

module slt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/slot_lifecycle_table.sv -----
// slot lifecycle table top level: id table with phase, persistence and dirty flags
// depends on slt_pkg, slt_req_if / slt_rsp_if and slt_ram
//
// usage:
//   req_i carries one request item (type, id, persistent value, state select);
//   it is taken only while the block is idle. rsp_o returns one result item
//   per request, or one per listed id for list requests (last marks the end);
//   unused request types give no result. cfg_we_i/cfg_wdata_i write the pool
//   capacity; a nonzero write stores it and empties the table.
// table walk:
//   ids live in a key ram and a metadata ram, both read one entry per cycle.
//   every request except clear and the unused types walks the whole table: once
//   for most requests, and for a list request once per match plus once more. a
//   walk is followed by an exec step for lookup requests, then a result step and
//   a return to idle; clear goes from idle straight to the result step, no walk.
// reset:
//   all slots invalid (flip-flop valid bits), live count zero, capacity 64.
//   no ram clearing pass is needed.
// stall:
//   a result stays in the output register until rsp_o.ready; the walk for the
//   next listed id begins only after the previous one is taken.
`default_nettype none

module slot_lifecycle_table #(
  parameter int unsigned ENTRIES = slt_pkg::ENTRIES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  slt_req_if.sink         req_i,
  slt_rsp_if.source       rsp_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned META_W = $bits(slt_pkg::meta_t);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

  slt_pkg::state_e state_q, state_d;
  slt_pkg::req_t   req_q, req_d;
  slt_pkg::rsp_t   out_q, out_d;
  slt_pkg::meta_t  rd_meta, meta_wdata, hit_meta_q, hit_meta_d;

  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    chk_q, chk_d;
  logic [IDX_W-1:0]        chk_idx_q, chk_idx_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    free_q, free_d;
  logic [IDX_W-1:0]        free_idx_q, free_idx_d;
  logic                    best_q, best_d;
  logic [slt_pkg::ID_W-1:0] best_key_q, best_key_d;
  logic                    have_prev_q, have_prev_d;
  logic [slt_pkg::ID_W-1:0] prev_q, prev_d;
  logic                    pend_q, pend_d;
  logic [slt_pkg::ID_W-1:0] pend_key_q, pend_key_d;
  logic                    more_q, more_d;
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [6:0]              alive_q, alive_d;
  logic [6:0]              cap_q, cap_d;

  // ram ports
  logic                     key_we, meta_we;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [slt_pkg::ID_W-1:0] rd_key;
  logic [META_W-1:0]        rd_meta_raw;

  assign rd_meta = slt_pkg::meta_t'(rd_meta_raw);

  slt_ram #(.WIDTH(slt_pkg::ID_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (req_q.entity_id),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  slt_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .raddr_i (raddr),
    .rdata_o (rd_meta_raw)
  );

  assign req_i.ready = (state_q == slt_pkg::S_IDLE);
  assign rsp_o.valid = (state_q == slt_pkg::S_RESP);
  assign rsp_o.status         = out_q.status;
  assign rsp_o.state_out      = out_q.state_out;
  assign rsp_o.registered_out = out_q.registered_out;
  assign rsp_o.persistent_out = out_q.persistent_out;
  assign rsp_o.live_count     = out_q.live_count;
  assign rsp_o.listed_id      = out_q.listed_id;
  assign rsp_o.listed_valid   = out_q.listed_valid;
  assign rsp_o.last           = out_q.last;

  logic entry_valid, is_list, list_match;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_d       = out_q;
    hit_meta_d  = hit_meta_q;
    idx_d       = idx_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_key_d  = best_key_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    pend_d      = pend_q;
    pend_key_d  = pend_key_q;
    more_d      = more_q;
    valid_d     = valid_q;
    alive_d     = alive_q;
    cap_d       = cap_q;
    key_we      = 1'b0;
    meta_we     = 1'b0;
    waddr       = chk_idx_q;
    raddr       = '0;
    meta_wdata  = rd_meta;

    entry_valid = valid_q[chk_idx_q];
    is_list     = req_q.req_type inside {slt_pkg::REQ_LIST, slt_pkg::REQ_DIRTY};
    if (req_q.req_type == slt_pkg::REQ_DIRTY) begin
      list_match = entry_valid && rd_meta.changed;
    end else begin
      list_match = entry_valid && (rd_meta.phase == req_q.state_select);
    end

    // capacity write empties the table
    if (cfg_we_i && (cfg_wdata_i != 7'd0)) begin
      cap_d   = cfg_wdata_i;
      valid_d = '0;
      alive_d = '0;
    end

    case (state_q)
      slt_pkg::S_IDLE: begin
        if (req_i.valid) begin
          req_d.req_type         = req_i.req_type;
          req_d.entity_id        = req_i.entity_id;
          req_d.persistent_value = req_i.persistent_value;
          req_d.state_select     = req_i.state_select;
          idx_d       = '0;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          best_d      = 1'b0;
          have_prev_d = 1'b0;
          pend_d      = 1'b0;
          more_d      = 1'b0;
          out_d       = '0;
          out_d.last  = 1'b1;
          if (req_i.req_type == slt_pkg::REQ_CLEAR) begin
            valid_d          = '0;
            alive_d          = '0;
            out_d.live_count = '0;
            state_d          = slt_pkg::S_RESP;
          end else if (req_i.req_type inside
                       {[slt_pkg::REQ_REGISTER : slt_pkg::REQ_CKPT]}) begin
            state_d = slt_pkg::S_SCAN;
          end
        end
      end

      slt_pkg::S_SCAN: begin
        // issue one read per cycle, check the entry read the cycle before
        if (idx_q < LAST_CNT) begin
          raddr     = idx_q[IDX_W-1:0];
          chk_d     = 1'b1;
          chk_idx_d = idx_q[IDX_W-1:0];
          idx_d     = idx_q + CNT_W'(1);
        end
        if (chk_q) begin
          if (req_q.req_type == slt_pkg::REQ_CKPT) begin
            meta_we            = 1'b1;
            meta_wdata.changed = 1'b0;
          end else if (is_list) begin
            if (list_match && (!have_prev_q || (rd_key > prev_q)) &&
                (!best_q || (rd_key < best_key_q))) begin
              best_d     = 1'b1;
              best_key_d = rd_key;
            end
          end else begin
            if (entry_valid && (rd_key == req_q.entity_id)) begin
              hit_d      = 1'b1;
              hit_idx_d  = chk_idx_q;
              hit_meta_d = rd_meta;
            end
            if (!entry_valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
          end
        end else if (idx_q == LAST_CNT) begin
          // walk finished
          out_d            = '0;
          out_d.live_count = alive_q;
          if (is_list) begin
            if (best_q) begin
              // hold the match until the next walk shows whether it is last
              pend_d      = 1'b1;
              pend_key_d  = best_key_q;
              prev_d      = best_key_q;
              have_prev_d = 1'b1;
              best_d      = 1'b0;
              idx_d       = '0;
              if (pend_q) begin
                out_d.listed_id    = pend_key_q;
                out_d.listed_valid = 1'b1;
                more_d             = 1'b1;
                state_d            = slt_pkg::S_RESP;
              end
            end else begin
              out_d.last = 1'b1;
              if (pend_q) begin
                out_d.listed_id    = pend_key_q;
                out_d.listed_valid = 1'b1;
              end
              more_d  = 1'b0;
              state_d = slt_pkg::S_RESP;
            end
          end else if (req_q.req_type == slt_pkg::REQ_CKPT) begin
            out_d.last = 1'b1;
            state_d    = slt_pkg::S_RESP;
          end else begin
            state_d = slt_pkg::S_EXEC;
          end
        end
      end

      slt_pkg::S_EXEC: begin
        out_d      = '0;
        out_d.last = 1'b1;
        more_d     = 1'b0;
        waddr      = hit_idx_q;
        meta_wdata = hit_meta_q;
        meta_wdata.changed = 1'b1;
        case (req_q.req_type)
          slt_pkg::REQ_REGISTER: begin
            if (req_q.entity_id == '0) begin
              out_d.status = slt_pkg::ST_ZERO_ID;
            end else if (hit_q) begin
              out_d.status = slt_pkg::ST_DUP;
            end else if (!free_q) begin
              out_d.status = slt_pkg::ST_TBL_FULL;
            end else begin
              waddr               = free_idx_q;
              key_we              = 1'b1;
              meta_we             = 1'b1;
              meta_wdata.phase    = slt_pkg::PH_DESPAWNED;
              meta_wdata.keep     = 1'b0;
              valid_d[free_idx_q] = 1'b1;
            end
          end
          slt_pkg::REQ_SPAWN: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else if (hit_meta_q.phase != slt_pkg::PH_DESPAWNED) begin
              out_d.status = slt_pkg::ST_WRONG;
            end else if (alive_q >= cap_q) begin
              out_d.status = slt_pkg::ST_POOL_FULL;
            end else begin
              meta_we          = 1'b1;
              meta_wdata.phase = slt_pkg::PH_ACTIVE;
              alive_d          = alive_q + 7'd1;
            end
          end
          slt_pkg::REQ_SLEEP: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else if (hit_meta_q.phase != slt_pkg::PH_ACTIVE) begin
              out_d.status = slt_pkg::ST_WRONG;
            end else begin
              meta_we          = 1'b1;
              meta_wdata.phase = slt_pkg::PH_SLEEPING;
            end
          end
          slt_pkg::REQ_WAKE: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else if (hit_meta_q.phase != slt_pkg::PH_SLEEPING) begin
              out_d.status = slt_pkg::ST_WRONG;
            end else begin
              meta_we          = 1'b1;
              meta_wdata.phase = slt_pkg::PH_ACTIVE;
            end
          end
          slt_pkg::REQ_DESPAWN: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else if (hit_meta_q.phase == slt_pkg::PH_DESPAWNED) begin
              out_d.status = slt_pkg::ST_WRONG;
            end else begin
              meta_we          = 1'b1;
              meta_wdata.phase = slt_pkg::PH_DESPAWNED;
              if (alive_q != 7'd0) begin
                alive_d = alive_q - 7'd1;
              end
            end
          end
          slt_pkg::REQ_SET_PERS: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else if (hit_meta_q.keep != req_q.persistent_value) begin
              meta_we         = 1'b1;
              meta_wdata.keep = req_q.persistent_value;
            end
          end
          slt_pkg::REQ_QUERY: begin
            if (!hit_q) begin
              out_d.status = slt_pkg::ST_NOT_FOUND;
            end else begin
              out_d.state_out      = hit_meta_q.phase;
              out_d.registered_out = 1'b1;
              out_d.persistent_out = hit_meta_q.keep;
            end
          end
          default: begin
            out_d.status = slt_pkg::ST_OK;
          end
        endcase
        out_d.live_count = alive_d;
        state_d          = slt_pkg::S_RESP;
      end

      slt_pkg::S_RESP: begin
        if (rsp_o.ready) begin
          state_d = more_q ? slt_pkg::S_SCAN : slt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = slt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slt_pkg::S_IDLE;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      best_q      <= 1'b0;
      have_prev_q <= 1'b0;
      pend_q      <= 1'b0;
      more_q      <= 1'b0;
      valid_q     <= '0;
      alive_q     <= '0;
      cap_q       <= slt_pkg::CAP_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      best_q      <= best_d;
      have_prev_q <= have_prev_d;
      pend_q      <= pend_d;
      more_q      <= more_d;
      valid_q     <= valid_d;
      alive_q     <= alive_d;
      cap_q       <= cap_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    out_q      <= out_d;
    hit_meta_q <= hit_meta_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    best_key_q <= best_key_d;
    prev_q     <= prev_d;
    pend_key_q <= pend_key_d;
  end

endmodule

`default_nettype wire

// ----- tb/slt_tb_checker.sv -----
// slot lifecycle table checker: watches the request and result channels,
// predicts every result item from its own table copy and compares them
// depends on slt_pkg and the slt_req_if / slt_rsp_if interfaces
`timescale 1ns / 100ps

module slt_tb_checker #(
  parameter int unsigned ENTRIES = slt_pkg::ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  slt_req_if.sink          req_mon,
  slt_rsp_if.sink          rsp_mon,
  output int unsigned      fail_count,
  output int unsigned      pending_count
);

  logic                     tbl_valid [ENTRIES];
  logic [slt_pkg::ID_W-1:0] tbl_key   [ENTRIES];
  logic [1:0]               tbl_phase [ENTRIES];
  logic                     tbl_keep  [ENTRIES];
  logic                     tbl_dirty [ENTRIES];
  int unsigned              live_total;
  int unsigned              capacity;
  slt_pkg::rsp_t            expected_rsp_q [$];

  assign pending_count = expected_rsp_q.size();

  function automatic void wipe_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_dirty[i] = 1'b0;
    end
    live_total = 0;
  endfunction

  function automatic int lookup(logic [slt_pkg::ID_W-1:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_rsp(logic [2:0] st, logic [1:0] ph, logic reg_b,
                                   logic keep_b, logic [slt_pkg::ID_W-1:0] lid,
                                   logic lval, logic lst);
    slt_pkg::rsp_t r;
    r.status = st; r.state_out = ph; r.registered_out = reg_b;
    r.persistent_out = keep_b; r.live_count = live_total[6:0];
    r.listed_id = lid; r.listed_valid = lval; r.last = lst;
    expected_rsp_q = {expected_rsp_q, r};
  endfunction

  // ascending walk over the matching ids
  function automatic void list_matches(logic by_dirty, logic [1:0] sel);
    logic [slt_pkg::ID_W-1:0] ids [$];
    logic                     hit;
    for (int i = 0; i < ENTRIES; i++) begin
      hit = tbl_valid[i] && (by_dirty ? tbl_dirty[i] : tbl_phase[i] == sel);
      if (hit) ids = {ids, tbl_key[i]};
    end
    ids.sort();
    if (ids.size() == 0)
      push_rsp(slt_pkg::ST_OK, 2'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
    foreach (ids[k])
      push_rsp(slt_pkg::ST_OK, 2'd0, 1'b0, 1'b0, ids[k], 1'b1, k == ids.size() - 1);
  endfunction

  function automatic void predict_request(logic [3:0] kind,
                                          logic [slt_pkg::ID_W-1:0] id,
                                          logic pv, logic [1:0] sel);
    logic [2:0] st;
    int s;
    st = slt_pkg::ST_OK;
    case (kind)
      slt_pkg::REQ_REGISTER: begin
        if (id == '0) st = slt_pkg::ST_ZERO_ID;
        else if (lookup(id) >= 0) st = slt_pkg::ST_DUP;
        else begin
          s = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i] && s < 0) s = i;
          if (s < 0) st = slt_pkg::ST_TBL_FULL;
          else begin
            tbl_valid[s] = 1'b1; tbl_key[s] = id; tbl_phase[s] = slt_pkg::PH_DESPAWNED;
            tbl_keep[s] = 1'b0; tbl_dirty[s] = 1'b1;
          end
        end
      end
      slt_pkg::REQ_SPAWN, slt_pkg::REQ_SLEEP, slt_pkg::REQ_WAKE,
      slt_pkg::REQ_DESPAWN: begin
        s = lookup(id);
        if (s < 0) st = slt_pkg::ST_NOT_FOUND;
        else if (kind == slt_pkg::REQ_SPAWN) begin
          if (tbl_phase[s] != slt_pkg::PH_DESPAWNED) st = slt_pkg::ST_WRONG;
          else if (live_total >= capacity) st = slt_pkg::ST_POOL_FULL;
          else begin tbl_phase[s] = slt_pkg::PH_ACTIVE; live_total++; end
        end else if (kind == slt_pkg::REQ_SLEEP) begin
          if (tbl_phase[s] != slt_pkg::PH_ACTIVE) st = slt_pkg::ST_WRONG;
          else tbl_phase[s] = slt_pkg::PH_SLEEPING;
        end else if (kind == slt_pkg::REQ_WAKE) begin
          if (tbl_phase[s] != slt_pkg::PH_SLEEPING) st = slt_pkg::ST_WRONG;
          else tbl_phase[s] = slt_pkg::PH_ACTIVE;
        end else begin
          if (tbl_phase[s] == slt_pkg::PH_DESPAWNED) st = slt_pkg::ST_WRONG;
          else begin
            tbl_phase[s] = slt_pkg::PH_DESPAWNED;
            if (live_total > 0) live_total--;
          end
        end
        if (s >= 0 && st == slt_pkg::ST_OK) tbl_dirty[s] = 1'b1;
      end
      slt_pkg::REQ_SET_PERS: begin
        s = lookup(id);
        if (s < 0) st = slt_pkg::ST_NOT_FOUND;
        else if (tbl_keep[s] != pv) begin
          tbl_keep[s] = pv; tbl_dirty[s] = 1'b1;
        end
      end
      slt_pkg::REQ_QUERY: begin
        s = lookup(id);
        if (s < 0)
          push_rsp(slt_pkg::ST_NOT_FOUND, 2'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        else
          push_rsp(slt_pkg::ST_OK, tbl_phase[s], 1'b1, tbl_keep[s], '0, 1'b0, 1'b1);
        return;
      end
      slt_pkg::REQ_LIST: begin list_matches(1'b0, sel); return; end
      slt_pkg::REQ_DIRTY: begin list_matches(1'b1, 2'd0); return; end
      slt_pkg::REQ_CKPT: for (int i = 0; i < ENTRIES; i++) tbl_dirty[i] = 1'b0;
      slt_pkg::REQ_CLEAR: wipe_table();
      default: return;
    endcase
    push_rsp(st, 2'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slt_pkg::rsp_t got, exp_r;
    if (!rst_ni) begin
      wipe_table();
      capacity = 64;
      expected_rsp_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we_i && cfg_wdata_i != 7'd0) begin
        capacity = 32'(cfg_wdata_i);
        wipe_table();
      end
      if (req_mon.valid && req_mon.ready)
        predict_request(req_mon.req_type, req_mon.entity_id,
                        req_mon.persistent_value, req_mon.state_select);
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status = rsp_mon.status; got.state_out = rsp_mon.state_out;
        got.registered_out = rsp_mon.registered_out;
        got.persistent_out = rsp_mon.persistent_out;
        got.live_count = rsp_mon.live_count; got.listed_id = rsp_mon.listed_id;
        got.listed_valid = rsp_mon.listed_valid; got.last = rsp_mon.last;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch, expected %p, got %p", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/slot_lifecycle_table_tb.sv -----
// slot lifecycle table testbench top: clock, reset, stimulus and verdict
// depends on slt_pkg, the channel interfaces, slt_tb_checker and the block
`timescale 1ns / 100ps

module slot_lifecycle_table_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = 7'd0;
  logic        rsp_stall_on = 1'b1;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  logic [slt_pkg::ID_W-1:0] id_pool [8];

  slt_req_if req_ch ();
  slt_rsp_if rsp_ch ();

  slot_lifecycle_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i), .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  slt_tb_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #6 clk_i = ~clk_i;

  // watchdog: a full list walks the whole table once per match and once more, plus stalls
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 10000000) begin
      $display("slot_lifecycle_table regression: fail");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random back-pressure, some stretches always ready
  initial begin
    int unsigned n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rsp_stall_on) rsp_ch.ready <= 1'b1;
      else begin
        n = gap_len();
        if (n == 0) rsp_ch.ready <= 1'b1;
        else begin
          rsp_ch.ready <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_item(logic [3:0] kind, logic [slt_pkg::ID_W-1:0] id, logic pv,
                           logic [1:0] sel, bit idle_gaps);
    int unsigned n;
    n = idle_gaps ? gap_len() : 0;
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.entity_id <= id;
    req_ch.persistent_value <= pv;
    req_ch.state_select <= sel;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // drop valid, wait for all results, then let the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (slt_pkg::ENTRIES_DEF + 10) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [slt_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return id_pool[$urandom_range(0, 7)];
  endfunction

  // random phase: lifecycle traffic on a small id pool, some unused kinds and random ids
  task automatic random_phase(int unsigned count);
    int unsigned r;
    logic [3:0] kind;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) kind = slt_pkg::REQ_REGISTER;
      else if (r < 75)
        kind = 4'($urandom_range(slt_pkg::REQ_SPAWN, slt_pkg::REQ_QUERY));
      else if (r < 85) kind = slt_pkg::REQ_LIST;
      else if (r < 90) kind = slt_pkg::REQ_DIRTY;
      else if (r < 94) kind = slt_pkg::REQ_CKPT;
      else if (r < 96) kind = slt_pkg::REQ_CLEAR;
      else kind = 4'($urandom_range(11, 15));
      send_item(kind, pick_id(), 1'($urandom), 2'($urandom), 1'b1);
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.entity_id = '0;
    req_ch.persistent_value = 1'b0;
    req_ch.state_select = 2'd0;
    id_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    id_pool[1] = 64'd1;
    id_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < 8; i++) id_pool[i] = {$urandom, $urandom};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every request kind and the corner statuses
    send_item(slt_pkg::REQ_REGISTER, '0, 1'b0, 2'd0, 1'b0);          // zero id
    send_item(slt_pkg::REQ_REGISTER, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_REGISTER, id_pool[0], 1'b0, 2'd0, 1'b0);  // duplicate
    send_item(slt_pkg::REQ_REGISTER, id_pool[1], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_REGISTER, id_pool[2], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_SPAWN, id_pool[3], 1'b0, 2'd0, 1'b0);     // not found
    send_item(slt_pkg::REQ_SLEEP, id_pool[0], 1'b0, 2'd0, 1'b0);     // wrong state
    send_item(slt_pkg::REQ_SPAWN, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_SPAWN, id_pool[0], 1'b0, 2'd0, 1'b0);     // wrong state
    send_item(slt_pkg::REQ_SLEEP, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_WAKE, id_pool[1], 1'b0, 2'd0, 1'b0);      // wrong state
    send_item(slt_pkg::REQ_SET_PERS, id_pool[0], 1'b1, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_SET_PERS, id_pool[0], 1'b1, 2'd0, 1'b0);  // no change
    send_item(slt_pkg::REQ_QUERY, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_QUERY, id_pool[4], 1'b0, 2'd0, 1'b0);     // unregistered
    send_item(slt_pkg::REQ_LIST, '0, 1'b0, 2'd2, 1'b0);
    send_item(slt_pkg::REQ_LIST, '0, 1'b0, 2'd3, 1'b0);              // empty select
    send_item(slt_pkg::REQ_DIRTY, '0, 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_CKPT, '0, 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_DIRTY, '0, 1'b0, 2'd0, 1'b0);             // empty list
    send_item(slt_pkg::REQ_WAKE, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_DESPAWN, id_pool[0], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_DESPAWN, id_pool[0], 1'b0, 2'd0, 1'b0);   // wrong state
    send_item(4'd15, id_pool[0], 1'b0, 2'd0, 1'b0);                  // ignored kind
    send_item(slt_pkg::REQ_CLEAR, '0, 1'b0, 2'd0, 1'b0);

    // capacity 1: pool full on the second spawn
    write_capacity(7'd1);
    send_item(slt_pkg::REQ_REGISTER, id_pool[1], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_REGISTER, id_pool[2], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_SPAWN, id_pool[1], 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_SPAWN, id_pool[2], 1'b0, 2'd0, 1'b0);
    random_phase(20);

    // zero write is ignored, then a mid capacity
    write_capacity(7'd0);
    random_phase(20);
    write_capacity(7'd3);
    rsp_stall_on <= 1'b0;
    random_phase(30);
    rsp_stall_on <= 1'b1;

    // fill the table to hit table full, list a large set once
    write_capacity(7'd127);
    for (int i = 0; i < slt_pkg::ENTRIES_DEF; i++)
      send_item(slt_pkg::REQ_REGISTER, {$urandom, $urandom} | 64'd1, 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_REGISTER, 64'd2, 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_LIST, '0, 1'b0, 2'd0, 1'b0);
    send_item(slt_pkg::REQ_CLEAR, '0, 1'b0, 2'd0, 1'b0);
    random_phase(30);
    write_capacity(7'd64);
    random_phase(30);

    drain();
    if (fail_count == 0) begin
      $display("slot_lifecycle_table regression: pass");
    end else begin
      $display("slot_lifecycle_table regression: fail");
    end
    $finish;
  end
endmodule
